FILE: rtl/page_range_free_list_allocator_top_assert.svh
// ----------------------------------------------------------------------------
// page_range_free_list_allocator_top_assert.svh
// Assertion macros shared by the allocator's checker.
// ----------------------------------------------------------------------------
`ifndef PAGE_RANGE_FREE_LIST_ALLOCATOR_TOP_ASSERT_SVH
`define PAGE_RANGE_FREE_LIST_ALLOCATOR_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define PFLA_ASSERT_NOW(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed: %m");

// Next-cycle implication, checked out of reset.
`define PFLA_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed: %m");

`endif

FILE: rtl/pfla_pkg.sv
// ----------------------------------------------------------------------------
// pfla_pkg
// Types, codes and command set of the page range free list allocator.
// ----------------------------------------------------------------------------
package pfla_pkg;

    // Internal page width: sums of a start page and a count need 22 bits.
    localparam int PW = 22;

    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_INIT  = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NOFIT = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic [1:0] CFG_FIRST_FREE = 2'd0;
    localparam logic [1:0] CFG_IO_BASE    = 2'd1;
    localparam logic [1:0] CFG_IO_COUNT   = 2'd2;
    localparam logic [1:0] CFG_LIMIT      = 2'd3;

    typedef struct packed {
        logic [1:0]  op;
        logic [19:0] base_page;
        logic [20:0] page_count;
    } req_t;

    typedef struct packed {
        logic [19:0] result_page;
        logic [1:0]  status;
    } rsp_t;

    // One free range: first page and exclusive last page.
    typedef struct packed {
        logic [PW-1:0] first;
        logic [PW-1:0] last;
    } entry_t;

    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_INIT_A,
        CMD_INIT_B,
        CMD_READ_I,
        CMD_SCAN_NEXT,
        CMD_ALLOC_HIT,
        CMD_NOFIT,
        CMD_FIND_NEXT,
        CMD_FIND_STOP,
        CMD_JOIN_BOTH,
        CMD_JOIN_PRED,
        CMD_JOIN_SUCC,
        CMD_FULL,
        CMD_INS_BEGIN,
        CMD_READ_KM1,
        CMD_INS_MOVE,
        CMD_INS_PUT,
        CMD_READ_KP1,
        CMD_RM_MOVE,
        CMD_RM_END,
        CMD_EMIT
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       i_at_end;
        logic       fit;
        logic       exact;
        logic       lt_lo;
        logic       empty_rng;
        logic       overlap;
        logic       join_pred;
        logic       join_succ;
        logic       full;
        logic       rm_last;
        logic       ins_last;
    } dp_stat_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_GB_CHECK,
        S_FIND_RD,
        S_FIND_CHK,
        S_DECIDE,
        S_INS_RD,
        S_INS_WR,
        S_RM_RD,
        S_RM_WR,
        S_GB_DONE,
        S_EMIT
    } state_t;

endpackage

FILE: rtl/pfla_ram.sv
// ----------------------------------------------------------------------------
// pfla_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pfla_ram #(
    parameter int WIDTH = 44,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/pfla_dp.sv
// ----------------------------------------------------------------------------
// pfla_dp
// Datapath: configuration registers, range table, pointers and result.
// ----------------------------------------------------------------------------
module pfla_dp #(
    parameter int MAX_RANGES = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  pfla_pkg::req_t    req,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [20:0]       cfg_data,
    input  pfla_pkg::dp_cmd_t cmd,
    output pfla_pkg::dp_stat_t stat,
    output logic              done,
    output pfla_pkg::rsp_t    rsp
);

    localparam int AW   = $clog2(MAX_RANGES);
    localparam int IDXW = $clog2(MAX_RANGES + 1);
    localparam int PW   = pfla_pkg::PW;

    logic [20:0] first_free_reg, io_base_reg, io_count_reg, limit_reg;
    logic [IDXW-1:0] cnt_reg, cnt_next;
    logic [IDXW-1:0] i_reg, i_next, k_reg, k_next;
    logic [IDXW-1:0] km1, kp1, im1;
    logic [PW-1:0]   lo_reg, lo_next, hi_reg, hi_next;
    logic [1:0]      op_reg, op_next;
    logic [20:0]     count_reg, count_next;
    pfla_pkg::entry_t pred_reg, pred_next, succ_reg, succ_next;
    logic [19:0]     res_reg, res_next;
    logic [1:0]      st_reg, st_next;
    logic            done_reg;
    pfla_pkg::rsp_t  rsp_reg;

    pfla_pkg::entry_t rd_data, wdata;
    logic             we, re;
    logic [AW-1:0]    waddr, raddr;
    logic [PW-1:0]    len;
    logic [IDXW:0]    kp1_wide;

    pfla_ram #(
        .WIDTH ($bits(pfla_pkg::entry_t)),
        .DEPTH (MAX_RANGES)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rd_data)
    );

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_free_reg <= '0;
            io_base_reg    <= '0;
            io_count_reg   <= '0;
            limit_reg      <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pfla_pkg::CFG_FIRST_FREE: first_free_reg <= cfg_data;
                pfla_pkg::CFG_IO_BASE:    io_base_reg    <= cfg_data;
                pfla_pkg::CFG_IO_COUNT:   io_count_reg   <= cfg_data;
                pfla_pkg::CFG_LIMIT:      limit_reg      <= cfg_data;
                default:                  limit_reg      <= limit_reg;
            endcase
        end
    end

    // Pointer arithmetic and status flags.
    assign km1      = k_reg - 1'b1;
    assign kp1      = k_reg + 1'b1;
    assign im1      = i_reg - 1'b1;
    assign kp1_wide = {1'b0, k_reg} + 1'b1;
    assign len      = rd_data.last - rd_data.first;

    always_comb
    begin
        stat.op        = op_reg;
        stat.i_at_end  = (i_reg == cnt_reg);
        stat.fit       = (len >= {1'b0, count_reg});
        stat.exact     = (len == {1'b0, count_reg});
        stat.lt_lo     = (rd_data.first < lo_reg);
        stat.empty_rng = (lo_reg >= hi_reg);
        stat.overlap   = ((i_reg != '0) && (pred_reg.last > lo_reg))
                       || ((i_reg != cnt_reg) && (succ_reg.first < hi_reg));
        stat.join_pred = (i_reg != '0) && (pred_reg.last == lo_reg);
        stat.join_succ = (i_reg != cnt_reg) && (succ_reg.first == hi_reg);
        stat.full      = (cnt_reg == IDXW'(MAX_RANGES));
        stat.rm_last   = (kp1_wide >= {1'b0, cnt_reg});
        stat.ins_last  = (k_reg == i_reg);
    end

    // Command decode: next values, table read and write.
    always_comb
    begin
        cnt_next   = cnt_reg;
        i_next     = i_reg;
        k_next     = k_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        op_next    = op_reg;
        count_next = count_reg;
        pred_next  = pred_reg;
        succ_next  = succ_reg;
        res_next   = res_reg;
        st_next    = st_reg;
        re         = 1'b0;
        raddr      = i_reg[AW-1:0];
        we         = 1'b0;
        waddr      = i_reg[AW-1:0];
        wdata      = '{first: lo_reg, last: hi_reg};
        case (cmd)
            pfla_pkg::CMD_LOAD:
            begin
                op_next    = req.op;
                count_next = req.page_count;
                lo_next    = {2'b00, req.base_page};
                hi_next    = {2'b00, req.base_page} + {1'b0, req.page_count};
                i_next     = '0;
                res_next   = '0;
                st_next    = pfla_pkg::ST_OK;
            end
            pfla_pkg::CMD_INIT_A:
            begin
                cnt_next = '0;
                i_next   = '0;
                lo_next  = {1'b0, first_free_reg};
                hi_next  = {1'b0, io_base_reg};
            end
            pfla_pkg::CMD_INIT_B:
            begin
                i_next  = '0;
                lo_next = {1'b0, io_base_reg} + {1'b0, io_count_reg};
                hi_next = {1'b0, limit_reg};
            end
            pfla_pkg::CMD_READ_I:
            begin
                re = 1'b1;
            end
            pfla_pkg::CMD_SCAN_NEXT:
            begin
                i_next = i_reg + 1'b1;
            end
            pfla_pkg::CMD_ALLOC_HIT:
            begin
                res_next = rd_data.first[19:0];
                k_next   = i_reg;
                we       = !stat.exact;
                wdata    = '{first: rd_data.first + {1'b0, count_reg},
                             last: rd_data.last};
            end
            pfla_pkg::CMD_NOFIT:
            begin
                st_next = pfla_pkg::ST_NOFIT;
            end
            pfla_pkg::CMD_FIND_NEXT:
            begin
                pred_next = rd_data;
                i_next    = i_reg + 1'b1;
            end
            pfla_pkg::CMD_FIND_STOP:
            begin
                succ_next = rd_data;
            end
            pfla_pkg::CMD_JOIN_BOTH:
            begin
                we     = 1'b1;
                waddr  = im1[AW-1:0];
                wdata  = '{first: pred_reg.first, last: succ_reg.last};
                k_next = i_reg;
            end
            pfla_pkg::CMD_JOIN_PRED:
            begin
                we    = 1'b1;
                waddr = im1[AW-1:0];
                wdata = '{first: pred_reg.first, last: hi_reg};
            end
            pfla_pkg::CMD_JOIN_SUCC:
            begin
                we    = 1'b1;
                wdata = '{first: lo_reg, last: succ_reg.last};
            end
            pfla_pkg::CMD_FULL:
            begin
                st_next = pfla_pkg::ST_FULL;
            end
            pfla_pkg::CMD_INS_BEGIN:
            begin
                k_next = cnt_reg;
            end
            pfla_pkg::CMD_READ_KM1:
            begin
                re    = 1'b1;
                raddr = km1[AW-1:0];
            end
            pfla_pkg::CMD_INS_MOVE:
            begin
                we     = 1'b1;
                waddr  = k_reg[AW-1:0];
                wdata  = rd_data;
                k_next = km1;
            end
            pfla_pkg::CMD_INS_PUT:
            begin
                we       = 1'b1;
                cnt_next = cnt_reg + 1'b1;
            end
            pfla_pkg::CMD_READ_KP1:
            begin
                re    = 1'b1;
                raddr = kp1[AW-1:0];
            end
            pfla_pkg::CMD_RM_MOVE:
            begin
                we     = 1'b1;
                waddr  = k_reg[AW-1:0];
                wdata  = rd_data;
                k_next = kp1;
            end
            pfla_pkg::CMD_RM_END:
            begin
                cnt_next = cnt_reg - 1'b1;
            end
            default:
            begin
                re = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= (cmd == pfla_pkg::CMD_EMIT);
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        i_reg     <= i_next;
        k_reg     <= k_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        op_reg    <= op_next;
        count_reg <= count_next;
        pred_reg  <= pred_next;
        succ_reg  <= succ_next;
        res_reg   <= res_next;
        st_reg    <= st_next;
        if (cmd == pfla_pkg::CMD_EMIT)
        begin
            rsp_reg <= '{result_page: res_reg, status: st_reg};
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

FILE: rtl/pfla_ctrl.sv
// ----------------------------------------------------------------------------
// pfla_ctrl
// Controller: sequences scans, merges, inserts and removals of the table.
// ----------------------------------------------------------------------------
module pfla_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  pfla_pkg::dp_stat_t stat,
    output pfla_pkg::dp_cmd_t  cmd,
    output logic               busy
);

    pfla_pkg::state_t state_reg, state_next;
    logic             second_reg, second_next;

    // State register; second marks the pending second range of an init.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= pfla_pkg::S_IDLE;
            second_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            second_reg <= second_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next  = state_reg;
        second_next = second_reg;
        cmd         = pfla_pkg::CMD_NONE;
        case (state_reg)
            pfla_pkg::S_IDLE:
            begin
                if (start)
                begin
                    cmd        = pfla_pkg::CMD_LOAD;
                    state_next = pfla_pkg::S_DISPATCH;
                end
            end
            pfla_pkg::S_DISPATCH:
            begin
                case (stat.op)
                    pfla_pkg::OP_ALLOC: state_next = pfla_pkg::S_SCAN_RD;
                    pfla_pkg::OP_FREE:  state_next = pfla_pkg::S_GB_CHECK;
                    pfla_pkg::OP_INIT:
                    begin
                        cmd         = pfla_pkg::CMD_INIT_A;
                        second_next = 1'b1;
                        state_next  = pfla_pkg::S_GB_CHECK;
                    end
                    default:            state_next = pfla_pkg::S_EMIT;
                endcase
            end
            pfla_pkg::S_SCAN_RD:
            begin
                if (stat.i_at_end)
                begin
                    cmd        = pfla_pkg::CMD_NOFIT;
                    state_next = pfla_pkg::S_EMIT;
                end
                else
                begin
                    cmd        = pfla_pkg::CMD_READ_I;
                    state_next = pfla_pkg::S_SCAN_CHK;
                end
            end
            pfla_pkg::S_SCAN_CHK:
            begin
                if (stat.fit)
                begin
                    cmd        = pfla_pkg::CMD_ALLOC_HIT;
                    state_next = stat.exact ? pfla_pkg::S_RM_RD : pfla_pkg::S_EMIT;
                end
                else
                begin
                    cmd        = pfla_pkg::CMD_SCAN_NEXT;
                    state_next = pfla_pkg::S_SCAN_RD;
                end
            end
            pfla_pkg::S_GB_CHECK:
            begin
                state_next = stat.empty_rng ? pfla_pkg::S_GB_DONE : pfla_pkg::S_FIND_RD;
            end
            pfla_pkg::S_FIND_RD:
            begin
                if (stat.i_at_end)
                begin
                    state_next = pfla_pkg::S_DECIDE;
                end
                else
                begin
                    cmd        = pfla_pkg::CMD_READ_I;
                    state_next = pfla_pkg::S_FIND_CHK;
                end
            end
            pfla_pkg::S_FIND_CHK:
            begin
                if (stat.lt_lo)
                begin
                    cmd        = pfla_pkg::CMD_FIND_NEXT;
                    state_next = pfla_pkg::S_FIND_RD;
                end
                else
                begin
                    cmd        = pfla_pkg::CMD_FIND_STOP;
                    state_next = pfla_pkg::S_DECIDE;
                end
            end
            pfla_pkg::S_DECIDE:
            begin
                // Overlap is ignored; otherwise merge, or insert if room.
                if (stat.overlap)
                begin
                    state_next = pfla_pkg::S_GB_DONE;
                end
                else if (stat.join_pred && stat.join_succ)
                begin
                    cmd        = pfla_pkg::CMD_JOIN_BOTH;
                    state_next = pfla_pkg::S_RM_RD;
                end
                else if (stat.join_pred)
                begin
                    cmd        = pfla_pkg::CMD_JOIN_PRED;
                    state_next = pfla_pkg::S_GB_DONE;
                end
                else if (stat.join_succ)
                begin
                    cmd        = pfla_pkg::CMD_JOIN_SUCC;
                    state_next = pfla_pkg::S_GB_DONE;
                end
                else if (stat.full)
                begin
                    cmd        = pfla_pkg::CMD_FULL;
                    state_next = pfla_pkg::S_GB_DONE;
                end
                else
                begin
                    cmd        = pfla_pkg::CMD_INS_BEGIN;
                    state_next = pfla_pkg::S_INS_RD;
                end
            end
            pfla_pkg::S_INS_RD:
            begin
                if (stat.ins_last)
                begin
                    cmd        = pfla_pkg::CMD_INS_PUT;
                    state_next = pfla_pkg::S_GB_DONE;
                end
                else
                begin
                    cmd        = pfla_pkg::CMD_READ_KM1;
                    state_next = pfla_pkg::S_INS_WR;
                end
            end
            pfla_pkg::S_INS_WR:
            begin
                cmd        = pfla_pkg::CMD_INS_MOVE;
                state_next = pfla_pkg::S_INS_RD;
            end
            pfla_pkg::S_RM_RD:
            begin
                if (stat.rm_last)
                begin
                    cmd        = pfla_pkg::CMD_RM_END;
                    state_next = pfla_pkg::S_GB_DONE;
                end
                else
                begin
                    cmd        = pfla_pkg::CMD_READ_KP1;
                    state_next = pfla_pkg::S_RM_WR;
                end
            end
            pfla_pkg::S_RM_WR:
            begin
                cmd        = pfla_pkg::CMD_RM_MOVE;
                state_next = pfla_pkg::S_RM_RD;
            end
            pfla_pkg::S_GB_DONE:
            begin
                if (second_reg)
                begin
                    cmd         = pfla_pkg::CMD_INIT_B;
                    second_next = 1'b0;
                    state_next  = pfla_pkg::S_GB_CHECK;
                end
                else
                begin
                    state_next = pfla_pkg::S_EMIT;
                end
            end
            pfla_pkg::S_EMIT:
            begin
                cmd        = pfla_pkg::CMD_EMIT;
                state_next = pfla_pkg::S_IDLE;
            end
            default:
            begin
                state_next = pfla_pkg::S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != pfla_pkg::S_IDLE);

endmodule

FILE: rtl/page_range_free_list_allocator_top.sv
// ----------------------------------------------------------------------------
// page_range_free_list_allocator_top
// First-fit page range allocator with a coalescing, address-sorted free list.
// ----------------------------------------------------------------------------
// Usage: present a request beat on req and raise start; it is taken at a
// clock edge where start is high and busy is low. busy stays high until the
// request is finished. Exactly one result beat follows each request: done is
// high for one cycle with result_page and status on rsp, and the receiver
// cannot hold it off. A new request may be started in that same cycle.
// Cost: each table entry scanned takes a registered RAM read and then a
// compare, and each entry shifted by an insert or a removal takes a read
// and then a write. Scanned and shifted entries of an allocate or a free
// together never exceed the range count. An init runs two frees back to
// back on a nearly empty table. The single registered table read port
// bounds the speed of each step. Configuration registers are written
// through cfg_we, cfg_index and cfg_data; the user must do so only while
// busy is low, and the block itself does not enforce it.
// Reset empties the table (the count goes to zero) and clears the
// configuration registers; no clearing pass is needed.
// ----------------------------------------------------------------------------
module page_range_free_list_allocator_top #(
    parameter int MAX_RANGES = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  pfla_pkg::req_t req,
    output logic           done,
    output pfla_pkg::rsp_t rsp,
    input  logic           cfg_we,
    input  logic [1:0]     cfg_index,
    input  logic [20:0]    cfg_data
);

    pfla_pkg::dp_cmd_t  cmd;
    pfla_pkg::dp_stat_t stat;

    pfla_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    pfla_dp #(
        .MAX_RANGES (MAX_RANGES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .done      (done),
        .rsp       (rsp)
    );

endmodule

FILE: rtl/pfla_checker.sv
// ----------------------------------------------------------------------------
// pfla_checker
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "page_range_free_list_allocator_top_assert.svh"

module pfla_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           start,
    input logic           busy,
    input pfla_pkg::rsp_t rsp,
    input logic           done
);

    // A result beat appears only once the block has gone idle.
    `PFLA_ASSERT_NOW(a_done_idle, clk, rst_n, done, !busy)

    // An accepted request keeps the block busy in the next cycle.
    `PFLA_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)

    // Finishing a request always produces a result beat.
    `PFLA_ASSERT_NOW(a_fall_done, clk, rst_n, $fell(busy), done)

    // A failed request carries no page.
    `PFLA_ASSERT_NOW(a_fail_zero, clk, rst_n,
        done && (rsp.status != pfla_pkg::ST_OK), rsp.result_page == '0)

    // Status codes stay within the defined set.
    `PFLA_ASSERT_NOW(a_status_code, clk, rst_n, done,
        (rsp.status == pfla_pkg::ST_OK) || (rsp.status == pfla_pkg::ST_NOFIT)
        || (rsp.status == pfla_pkg::ST_FULL))

endmodule

bind page_range_free_list_allocator_top pfla_checker u_pfla_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .rsp   (rsp),
    .done  (done)
);

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// Page range allocator testbench
// Drives allocate, free and initialize commands into the allocator, predicts
// every result beat with a behavioral model of the sorted free range table,
// and compares each beat field by field. Runs several idle phases and
// several register settings, including the extremes.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_RANGES = 32;
    localparam int RANDOM_ITEMS = 2000;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    pfla_pkg::req_t   req;
    logic             done;
    pfla_pkg::rsp_t   rsp;
    logic             cfg_we;
    logic [1:0]       cfg_index;
    logic [20:0]      cfg_data;

    page_range_free_list_allocator_top #(.MAX_RANGES(NUM_RANGES)) DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .req(req),
        .done(done), .rsp(rsp), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // Predictor state: a copy of the free table and the registers.
    logic [21:0] free_lo [NUM_RANGES];
    logic [21:0] free_hi [NUM_RANGES];
    int          free_used;
    logic [20:0] reg_first, reg_io_base, reg_io_count, reg_limit;

    pfla_pkg::rsp_t pending_rsp [$];
    int             error_count;
    int             beats_seen;
    int             sender_idle;

    // Directed stimulus row: request plus an optional typed-in result.
    typedef struct {
        pfla_pkg::req_t rq;
        bit             has_fixed;
        pfla_pkg::rsp_t fixed;
    } stim_row_t;

    always #1 clk = ~clk;

    task automatic report_mismatch(input string what);
        begin
            $display("MISMATCH at %0t: %s", $realtime, what);
            error_count++;
        end
    endtask

    // Remove table entry idx, closing the gap.
    function automatic void drop_range(input int idx);
        begin
            for (int k = idx; k + 1 < free_used; k++)
            begin
                free_lo[k] = free_lo[k + 1];
                free_hi[k] = free_hi[k + 1];
            end
            free_used--;
        end
    endfunction

    // Return [lo, hi) to the table; merges neighbors, ignores empty or overlapping ranges, reports a full table.
    function automatic logic [1:0] return_range(input logic [21:0] lo,
                                                input logic [21:0] hi);
        int  i;
        bit  pred, succ, jp, js;
        begin
            i = 0;
            if (lo >= hi) return pfla_pkg::ST_OK;
            while (i < free_used && free_lo[i] < lo) i++;
            pred = i > 0;
            succ = i < free_used;
            if (pred && free_hi[i - 1] > lo) return pfla_pkg::ST_OK;
            if (succ && free_lo[i] < hi) return pfla_pkg::ST_OK;
            jp = pred && free_hi[i - 1] == lo;
            js = succ && free_lo[i] == hi;
            if (jp && js)
            begin
                free_hi[i - 1] = free_hi[i];
                drop_range(i);
            end
            else if (jp) free_hi[i - 1] = hi;
            else if (js) free_lo[i] = lo;
            else
            begin
                if (free_used >= NUM_RANGES) return pfla_pkg::ST_FULL;
                for (int k = free_used; k > i; k--)
                begin
                    free_lo[k] = free_lo[k - 1];
                    free_hi[k] = free_hi[k - 1];
                end
                free_lo[i] = lo;
                free_hi[i] = hi;
                free_used++;
            end
            return pfla_pkg::ST_OK;
        end
    endfunction

    // Expected result of one command; updates the predicted table.
    function automatic pfla_pkg::rsp_t allocator_result(input pfla_pkg::req_t rq);
        pfla_pkg::rsp_t r;
        logic [21:0]    len;
        begin
            r.result_page = '0;
            r.status = pfla_pkg::ST_OK;
            if (rq.op == pfla_pkg::OP_ALLOC)
            begin
                r.status = pfla_pkg::ST_NOFIT;
                for (int i = 0; i < free_used; i++)
                begin
                    len = free_hi[i] - free_lo[i];
                    if (len >= {1'b0, rq.page_count})
                    begin
                        r.result_page = free_lo[i][19:0];
                        r.status = pfla_pkg::ST_OK;
                        if (len == {1'b0, rq.page_count}) drop_range(i);
                        else free_lo[i] = free_lo[i] + {1'b0, rq.page_count};
                        break;
                    end
                end
            end
            else if (rq.op == pfla_pkg::OP_FREE)
                r.status = return_range({2'b0, rq.base_page},
                                        {2'b0, rq.base_page} + {1'b0, rq.page_count});
            else if (rq.op == pfla_pkg::OP_INIT)
            begin
                free_used = 0;
                void'(return_range({1'b0, reg_first}, {1'b0, reg_io_base}));
                void'(return_range({1'b0, reg_io_base} + {1'b0, reg_io_count},
                                   {1'b0, reg_limit}));
            end
            return r;
        end
    endfunction

    // Check every result beat against the oldest expectation.
    always @(posedge clk)
    begin
        pfla_pkg::rsp_t want;
        if (rst_n && done)
        begin
            beats_seen++;
            if (pending_rsp.size() == 0)
                report_mismatch("result beat with nothing expected");
            else
            begin
                want = pending_rsp.pop_front();
                if (rsp.result_page !== want.result_page)
                    report_mismatch($sformatf("result_page got %0h want %0h",
                                              rsp.result_page, want.result_page));
                if (rsp.status !== want.status)
                    report_mismatch($sformatf("status got %0d want %0d",
                                              rsp.status, want.status));
            end
        end
    end

    // Write one register while the block is idle.
    task automatic write_reg(input logic [1:0] idx, input logic [20:0] val);
        begin
            @(negedge clk);
            cfg_we <= 1'b1;
            cfg_index <= idx;
            cfg_data <= val;
            @(negedge clk);
            cfg_we <= 1'b0;
            case (idx)
                pfla_pkg::CFG_FIRST_FREE: reg_first = val;
                pfla_pkg::CFG_IO_BASE:    reg_io_base = val;
                pfla_pkg::CFG_IO_COUNT:   reg_io_count = val;
                default:                  reg_limit = val;
            endcase
        end
    endtask

    // Send one command beat; fixed_rsp replaces the prediction when given.
    // Called at a falling edge; busy is stable there, so a beat raised while
    // busy is low is taken at the very next rising edge.
    task automatic send_command(input pfla_pkg::req_t rq, input bit has_fixed,
                                input pfla_pkg::rsp_t fixed_rsp);
        pfla_pkg::rsp_t predicted;
        begin
            while (sender_idle > 0 && $urandom_range(99) < sender_idle)
            begin
                start <= 1'b0;
                @(negedge clk);
            end
            while (busy)
            begin
                start <= 1'b0;
                @(negedge clk);
            end
            start <= 1'b1;
            req <= rq;
            predicted = allocator_result(rq);
            if (has_fixed && predicted !== fixed_rsp)
                report_mismatch("directed row disagrees with predictor");
            pending_rsp.push_back(has_fixed ? fixed_rsp : predicted);
            @(negedge clk);
            start <= 1'b0;
        end
    endtask

    // Wait for all outstanding beats, then a wait that covers the worst-case latency.
    task automatic drain;
        begin
            while (pending_rsp.size() != 0) @(negedge clk);
            repeat (4 * NUM_RANGES + 20) @(negedge clk);
        end
    endtask

    function automatic pfla_pkg::req_t make_req(input logic [1:0] op,
                                                input logic [19:0] base,
                                                input logic [20:0] cnt);
        pfla_pkg::req_t r;
        begin
            r.op = op;
            r.base_page = base;
            r.page_count = cnt;
            return r;
        end
    endfunction

    function automatic pfla_pkg::rsp_t make_rsp(input logic [19:0] pg,
                                                input logic [1:0] st);
        pfla_pkg::rsp_t r;
        begin
            r.result_page = pg;
            r.status = st;
            return r;
        end
    endfunction

    // Random command biased toward well-formed alloc/free traffic.
    function automatic pfla_pkg::req_t random_command(input int span);
        int             pick;
        pfla_pkg::req_t r;
        begin
            pick = $urandom_range(99);
            r.base_page = 20'($urandom_range(span));
            r.page_count = 21'($urandom_range(span / 8 + 1));
            if (pick < 45) r.op = pfla_pkg::OP_ALLOC;
            else if (pick < 90) r.op = pfla_pkg::OP_FREE;
            else if (pick < 93) r.op = pfla_pkg::OP_INIT;
            else if (pick < 95) r.op = 2'd3;
            else
            begin
                // Noise over the full field widths.
                r.op = 2'($urandom_range(3));
                r.base_page = 20'($urandom);
                r.page_count = 21'($urandom);
            end
            return r;
        end
    endfunction

    initial
    begin
        stim_row_t      rows [$];
        pfla_pkg::rsp_t none;
        int             span;
        int             phase_idle [4];
        logic [20:0]    settings [4][4];

        clk = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        req = '0;
        cfg_we = 1'b0;
        cfg_index = pfla_pkg::CFG_FIRST_FREE;
        cfg_data = '0;
        free_used = 0;
        reg_first = '0;
        reg_io_base = '0;
        reg_io_count = '0;
        reg_limit = '0;
        error_count = 0;
        beats_seen = 0;
        sender_idle = 0;
        none = '0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // Directed rows: empty table, zero-sized cases, unused op, merges, extreme sizes and a full table.
        rows.push_back('{make_req(pfla_pkg::OP_ALLOC, 0, 1), 1,
                         make_rsp(0, pfla_pkg::ST_NOFIT)});
        rows.push_back('{make_req(pfla_pkg::OP_ALLOC, 0, 0), 1,
                         make_rsp(0, pfla_pkg::ST_NOFIT)});
        rows.push_back('{make_req(pfla_pkg::OP_INIT, 0, 0), 1,
                         make_rsp(0, pfla_pkg::ST_OK)});
        rows.push_back('{make_req(pfla_pkg::OP_FREE, 20'hFFFFF, 0), 1,
                         make_rsp(0, pfla_pkg::ST_OK)});
        rows.push_back('{make_req(2'd3, 20'hFFFFF, 21'h1FFFFF), 1,
                         make_rsp(0, pfla_pkg::ST_OK)});
        rows.push_back('{make_req(pfla_pkg::OP_FREE, 100, 10), 0, none});
        rows.push_back('{make_req(pfla_pkg::OP_FREE, 120, 10), 0, none});
        rows.push_back('{make_req(pfla_pkg::OP_FREE, 105, 3), 0, none});
        rows.push_back('{make_req(pfla_pkg::OP_FREE, 110, 10), 0, none});
        rows.push_back('{make_req(pfla_pkg::OP_ALLOC, 0, 0), 1,
                         make_rsp(100, pfla_pkg::ST_OK)});
        rows.push_back('{make_req(pfla_pkg::OP_ALLOC, 0, 30), 1,
                         make_rsp(100, pfla_pkg::ST_OK)});
        rows.push_back('{make_req(pfla_pkg::OP_FREE, 20'hFFFFF, 21'h100000), 0, none});
        rows.push_back('{make_req(pfla_pkg::OP_FREE, 0, 21'h1FFFFF), 0, none});
        rows.push_back('{make_req(pfla_pkg::OP_ALLOC, 0, 21'h1FFFFF), 0, none});
        rows.push_back('{make_req(pfla_pkg::OP_ALLOC, 0, 21'h100000), 0, none});
        for (int k = 0; k < NUM_RANGES + 1; k++)
            rows.push_back('{make_req(pfla_pkg::OP_FREE, 20'(1000 + 2 * k), 1),
                             0, none});
        foreach (rows[n]) send_command(rows[n].rq, rows[n].has_fixed,
                                       rows[n].fixed);
        drain();

        // Register settings: extremes, a gapless window, and typical layouts.
        settings = '{'{21'd0, 21'd0, 21'd0, 21'h100000},
                     '{21'd16, 21'd200, 21'd0, 21'd400},
                     '{21'd1, 21'h80000, 21'h7FFFF, 21'h100000},
                     '{21'd8, 21'd300, 21'd50, 21'd700}};
        phase_idle = '{0, 45, 0, 23};
        for (int p = 0; p < 4; p++)
        begin
            write_reg(pfla_pkg::CFG_FIRST_FREE, settings[p][0]);
            write_reg(pfla_pkg::CFG_IO_BASE, settings[p][1]);
            write_reg(pfla_pkg::CFG_IO_COUNT, settings[p][2]);
            write_reg(pfla_pkg::CFG_LIMIT, settings[p][3]);
            sender_idle = phase_idle[p];
            span = (p == 2) ? 20'hFFFFF : 800;
            send_command(make_req(pfla_pkg::OP_INIT, 0, 0), 1,
                         make_rsp(0, pfla_pkg::ST_OK));
            for (int n = 0; n < RANDOM_ITEMS / 4; n++)
                send_command(random_command(span), 0, none);
            drain();
        end

        $display("Ran directed and random allocate, free and init commands");
        $display("over four register settings; %0d result beats checked.",
                 beats_seen);
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #5000000;
        $display("simulation failed");
        $finish;
    end
endmodule
